>>> rtl/core/lirs_pkg.sv
package lirs_pkg;

  localparam int MAX_CHANNELS = 2;
  localparam int CH_BITS      = 1;
  localparam int NCH_BITS     = 2;
  localparam int SAMPLE_BITS  = 16;
  localparam int FRAC_BITS    = 16;
  localparam int STEP_BITS    = 21;
  localparam int CFG_IDX_BITS = 2;

  localparam logic [STEP_BITS-1:0] PHASE_ONE = STEP_BITS'(1) << FRAC_BITS;
  localparam logic [STEP_BITS-1:0] STEP_MIN  = PHASE_ONE >> 4;
  localparam logic [STEP_BITS-1:0] STEP_RST  = PHASE_ONE;

  localparam logic [CFG_IDX_BITS-1:0] REG_PHASE_STEP   = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_NUM_CHANNELS = 2'd1;

  // Controller to datapath.
  typedef struct packed {
    logic load;         // latch the incoming request
    logic apply;        // stream clear and frame store
    logic first;        // first frame of a stream
    logic finish;       // no position in this frame
    logic begin_frame;  // start emitting at channel 0
    logic mult;         // register difference times fraction
    logic emit;         // load output register and advance
  } cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic frame_done;
    logic have_prev;
    logic phase_lt_one;
    logic last_chan;
    logic wrap;
    logic out_free;
  } status_t;

endpackage

>>> rtl/core/lirs_ctrl.sv
module lirs_ctrl import lirs_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  output logic    in_stall,
  input  status_t sts,
  output cmd_t    cmd
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_APPLY = 3'd1;
  localparam logic [2:0] S_CHECK = 3'd2;
  localparam logic [2:0] S_MUL   = 3'd3;
  localparam logic [2:0] S_OUT   = 3'd4;

  logic [2:0] state;
  logic [2:0] state_next;

  assign in_stall = (state != S_IDLE);

  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_APPLY;
        end
      end
      S_APPLY: begin
        cmd.apply  = 1'b1;
        state_next = sts.frame_done ? S_CHECK : S_IDLE;
      end
      S_CHECK: begin
        if (!sts.have_prev) begin
          cmd.first  = 1'b1;
          state_next = S_IDLE;
        end else if (sts.phase_lt_one) begin
          cmd.begin_frame = 1'b1;
          state_next      = S_MUL;
        end else begin
          cmd.finish = 1'b1;
          state_next = S_IDLE;
        end
      end
      S_MUL: begin
        cmd.mult   = 1'b1;
        state_next = S_OUT;
      end
      S_OUT: begin
        if (sts.out_free) begin
          cmd.emit   = 1'b1;
          state_next = (sts.last_chan && sts.wrap) ? S_IDLE : S_MUL;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

`ifndef NO_ASSERTIONS
  a_emit_free: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> sts.out_free)
    else $error("result emitted into a full output register");

  a_accept_apply: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> (state == S_APPLY))
    else $error("accepted request not applied next cycle");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (state == S_OUT && !sts.out_free) |=> (state == S_OUT))
    else $error("left output state while output blocked");

  a_phase_in_frame: assert property (@(posedge clk) disable iff (rst)
    (cmd.emit && sts.last_chan && !sts.wrap) |=> sts.phase_lt_one)
    else $error("phase left the frame without wrapping");
`endif

endmodule

>>> rtl/core/lirs_dp.sv
module lirs_dp import lirs_pkg::*; (
  input  logic                          clk,
  input  logic                          rst,
  input  cmd_t                          cmd,
  output status_t                       sts,
  input  logic                          cfg_valid,
  input  logic [CFG_IDX_BITS-1:0]       cfg_index,
  input  logic [STEP_BITS-1:0]          cfg_data,
  input  logic signed [SAMPLE_BITS-1:0] sample_in,
  input  logic [CH_BITS-1:0]            channel_in,
  input  logic                          stream_start,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic signed [SAMPLE_BITS-1:0] sample_out,
  output logic [CH_BITS-1:0]            channel_out,
  output logic                          last_out
);

  localparam int PROD_BITS = 2 * (SAMPLE_BITS + 1);
  localparam int RND_BITS  = PROD_BITS - FRAC_BITS;

  logic [STEP_BITS-1:0]          phase_step;
  logic [1:0]                    num_channels;
  logic signed [SAMPLE_BITS-1:0] req_sample;
  logic [CH_BITS-1:0]            req_ch;
  logic                          req_start;
  logic signed [SAMPLE_BITS-1:0] cur  [MAX_CHANNELS];
  logic signed [SAMPLE_BITS-1:0] prev [MAX_CHANNELS];
  logic [STEP_BITS-1:0]          phase;
  logic                          have_prev;
  logic [CH_BITS-1:0]            chan;
  logic signed [PROD_BITS-1:0]   prod;

  logic [NCH_BITS-1:0]           nch;
  logic [STEP_BITS-1:0]          step_eff;
  logic [STEP_BITS:0]            phase_sum;
  logic signed [SAMPLE_BITS:0]   diff;
  logic signed [PROD_BITS-1:0]   prod_rnd;
  logic signed [RND_BITS-1:0]    delta;
  logic signed [RND_BITS-1:0]    blend;
  logic                          keep_frame;

  always_comb begin
    if (num_channels == 2'd0) begin
      nch = NCH_BITS'(1);
    end else if (num_channels > NCH_BITS'(MAX_CHANNELS)) begin
      nch = NCH_BITS'(MAX_CHANNELS);
    end else begin
      nch = num_channels;
    end
  end

  assign step_eff  = (phase_step < STEP_MIN) ? STEP_MIN : phase_step;
  assign phase_sum = {1'b0, phase} + {1'b0, step_eff};
  assign diff      = {cur[chan][SAMPLE_BITS-1], cur[chan]}
                   - {prev[chan][SAMPLE_BITS-1], prev[chan]};
  assign prod_rnd  = prod + PROD_BITS'(1 << (FRAC_BITS - 1));
  assign delta     = prod_rnd[PROD_BITS-1:FRAC_BITS];
  assign blend     = RND_BITS'(prev[chan]) + delta;

  // The current frame becomes history once the frame is fully handled.
  assign keep_frame = cmd.first || cmd.finish || (cmd.emit && sts.last_chan && sts.wrap);

  assign sts.frame_done   = ({1'b0, req_ch} == (nch - NCH_BITS'(1)));
  assign sts.have_prev    = have_prev;
  assign sts.phase_lt_one = (phase < PHASE_ONE);
  assign sts.last_chan    = ({1'b0, chan} == (nch - NCH_BITS'(1)));
  assign sts.wrap         = (phase_sum >= {1'b0, PHASE_ONE});
  assign sts.out_free     = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase_step   <= STEP_RST;
      num_channels <= 2'd1;
    end else if (cfg_valid) begin
      if (cfg_index == REG_PHASE_STEP) begin
        phase_step <= cfg_data;
      end else if (cfg_index == REG_NUM_CHANNELS) begin
        num_channels <= cfg_data[1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_sample <= sample_in;
      req_ch     <= channel_in;
      req_start  <= stream_start;
    end
    if (cmd.mult) begin
      prod <= PROD_BITS'(diff) * $signed({1'b0, phase[FRAC_BITS-1:0]});
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int c = 0; c < MAX_CHANNELS; c++) begin
        cur[c]  <= '0;
        prev[c] <= '0;
      end
      phase     <= '0;
      have_prev <= 1'b0;
      chan      <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && !out_stall && !cmd.emit) begin
        out_valid <= 1'b0;
      end
      if (cmd.apply) begin
        if (req_start) begin
          for (int c = 0; c < MAX_CHANNELS; c++) begin
            prev[c] <= '0;
          end
          phase     <= '0;
          have_prev <= 1'b0;
        end
        if ({1'b0, req_ch} < nch) begin
          cur[req_ch] <= req_sample;
        end
      end
      // Copy only the channels in use; the others keep their history.
      if (keep_frame) begin
        for (int c = 0; c < MAX_CHANNELS; c++) begin
          if (NCH_BITS'(c) < nch) begin
            prev[c] <= cur[c];
          end
        end
      end
      if (cmd.first) begin
        have_prev <= 1'b1;
        phase     <= '0;
      end
      if (cmd.finish) begin
        phase <= phase - PHASE_ONE;
      end
      if (cmd.begin_frame) begin
        chan <= '0;
      end
      if (cmd.emit) begin
        out_valid   <= 1'b1;
        sample_out  <= blend[SAMPLE_BITS-1:0];
        channel_out <= chan;
        last_out    <= sts.last_chan && sts.wrap;
        if (sts.last_chan) begin
          chan <= '0;
          if (sts.wrap) begin
            phase <= STEP_BITS'(phase_sum - {1'b0, PHASE_ONE});
          end else begin
            phase <= phase_sum[STEP_BITS-1:0];
          end
        end else begin
          chan <= chan + CH_BITS'(1);
        end
      end
    end
  end

endmodule

>>> rtl/core/linear_interp_resampler.sv
// Linear-interpolation sample-rate converter. Interleaved signed 16-bit PCM
// samples arrive one channel per request; when the last channel of a frame
// arrives, every output position whose Q16 phase lies in [0, 1) between the
// previous and the current frame is emitted, channel by channel, as
// prev + round((cur - prev) * frac), halves rounded up. last_out marks the
// final result caused by a request. phase_step (register 0, unsigned Q16,
// clamped to at least 1/16) sets input samples per output sample;
// num_channels (register 1) sets channels per frame (0 acts as 1, above 2
// acts as 2). stream_start clears phase and history before its sample is
// taken. A request that does not complete a frame is accepted, then stored;
// a completing request is accepted, stored and checked, then each result
// takes one multiply stage and one output load, up to 32 results per
// request; out_stall holding the output register stalls the sequence. The
// shared multiplier and the single output register serialize the results;
// one request is in flight at a time.
module linear_interp_resampler import lirs_pkg::*; (
  input  logic                          clk,
  input  logic                          rst,
  // input samples
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic signed [SAMPLE_BITS-1:0] sample_in,
  input  logic [CH_BITS-1:0]            channel_in,
  input  logic                          stream_start,
  // resampled output
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic signed [SAMPLE_BITS-1:0] sample_out,
  output logic [CH_BITS-1:0]            channel_out,
  output logic                          last_out,
  // register writes
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [CFG_IDX_BITS-1:0]       cfg_index,
  input  logic [STEP_BITS-1:0]          cfg_data
);

  cmd_t    cmd;
  status_t sts;

  // Registers must be written only while idle; the block does not enforce this, so always take the write.
  assign cfg_ready = 1'b1;

  // Sequence each request: store, decide, then multiply and emit per result.
  lirs_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  // Frame history, phase accumulator, multiplier and output register.
  lirs_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .sts          (sts),
    .cfg_valid    (cfg_valid),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .sample_in    (sample_in),
    .channel_in   (channel_in),
    .stream_start (stream_start),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .sample_out   (sample_out),
    .channel_out  (channel_out),
    .last_out     (last_out)
  );

endmodule
